@@ sv/pwmpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the PWM prescaler and duty calculator.
package pwmpd_pkg;

	localparam int unsigned CLOCK_HZ         = 48000000;
	localparam int unsigned TIMER_TOP_LIMIT  = 1023;
	localparam int unsigned MAX_PRESCALE_EXP = 14;

	localparam int FREQ_W     = 26;
	localparam int RESET_FREQ = 10000;
	localparam int SPEED_W    = 16;
	localparam int CS_W       = 4;
	localparam int TOP_W      = 10;
	localparam int DUTY_SHIFT = 10;
	localparam int FULL_DUTY  = 1024;
	localparam int DUTY_W     = 11;
	localparam int PROD_W     = TOP_W + DUTY_W;

	// quotient width follows the clock constant, the step counter follows the quotient
	localparam int QUO_W = $clog2(CLOCK_HZ + 1);
	localparam int CNT_W = $clog2(QUO_W + 1);

	// APB register map: one 26-bit register on the 32-bit bus, word index in paddr[2]
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_FREQUENCY = 1'b0;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

@@ sv/pwmpd_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider: CLOCK_HZ / divisor, one quotient bit per cycle.
module pwmpd_div import pwmpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FREQ_W-1:0] divisor,
	output logic [QUO_W-1:0]  quotient,
	output div_status_t       status
);

	div_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [FREQ_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [FREQ_W-1:0] dvs_q;

	logic [FREQ_W:0] wide;
	logic [FREQ_W:0] diff;
	logic            ge;
	logic            last;

	// partial remainder with the next dividend bit shifted in
	assign wide = {rem_q, quo_q[QUO_W-1]};
	assign diff = wide - {1'b0, dvs_q};
	assign ge   = (wide >= {1'b0, dvs_q});
	assign last = (cnt_q == CNT_W'(QUO_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (last) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DIV_RUN) && last;
			if (state_q == DIV_IDLE) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// dividend sits in quo_q and shifts out MSB first as quotient bits shift in
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q <= '0;
			quo_q <= QUO_W'(CLOCK_HZ);
			dvs_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : wide[FREQ_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = (state_q == DIV_RUN);
	assign status.done = done_q;

endmodule

@@ sv/pwm_prescaler_and_duty_calc_core.sv @@
`timescale 1ns / 1ps
// PWM prescaler and duty calculator, top level.
// done pulses once an accepted start transfer has passed duty pipeline stages s1 to s4.
// Throughput: one speed command per cycle while busy is low; the four-stage pipeline
// never stalls. After reset and after each frequency write, busy stays high while the
// shared bit-serial divider recomputes the timer settings.
// Reset is asynchronous, active low; frequency returns to 10000 Hz.
module pwm_prescaler_and_duty_calc_core import pwmpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [SPEED_W-1:0] speed,
	// result channel
	output logic              done,
	output logic [CS_W-1:0]   clock_select,
	output logic [TOP_W-1:0]  top_value,
	output logic [TOP_W-1:0]  compare_value,
	output logic              output_enable,
	output logic              freq_out_of_range,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [FREQ_W-1:0] freq_q;
	logic              cfg_wr;
	logic              recalc_q;   // settings must be recomputed

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_W'(RESET_FREQ);
		end else if (cfg_wr && paddr[2] == REG_FREQUENCY) begin
			freq_q <= pwdata[FREQ_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FREQUENCY) begin
			prdata = DATA_W'(freq_q);
		end
	end

	// ------------------------------------------------------------------
	// Timer settings: computed once per frequency, held for every command.
	// recalc_q comes out of reset set so the reset frequency is worked out too.
	// ------------------------------------------------------------------
	logic [QUO_W-1:0] cycles;
	div_status_t      div_st;
	logic             div_start;

	assign div_start = recalc_q && !div_st.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recalc_q <= 1'b1;
		end else if (cfg_wr && paddr[2] == REG_FREQUENCY) begin
			recalc_q <= 1'b1;
		end else if (div_start) begin
			recalc_q <= 1'b0;
		end
	end

	pwmpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (freq_q),
		.quotient (cycles),
		.status   (div_st)
	);

	// Smallest prescale 2^k whose top limit exceeds the period. The fifteen
	// compares against constants are independent; the loop only picks the first.
	logic [CS_W-1:0]  sel_cs;
	logic [TOP_W-1:0] sel_top;
	logic             sel_oor;

	always_comb begin
		logic found;
		found   = 1'b0;
		sel_cs  = '0;
		sel_top = '0;
		for (int k = 0; k <= int'(MAX_PRESCALE_EXP); k++) begin
			if (!found && (64'(cycles) < (64'(TIMER_TOP_LIMIT) << k))) begin
				found   = 1'b1;
				sel_cs  = CS_W'(k + 1);
				sel_top = TOP_W'(cycles >> k);
			end
		end
		// zero frequency cannot be divided by: no prescale fits
		if (freq_q == '0) begin
			found   = 1'b0;
			sel_cs  = '0;
			sel_top = '0;
		end
		sel_oor = !found;
	end

	logic [CS_W-1:0]  cs_q;
	logic [TOP_W-1:0] top_q;
	logic             oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q  <= '0;
			top_q <= '0;
			oor_q <= 1'b1;
		end else if (div_st.done) begin
			cs_q  <= sel_cs;
			top_q <= sel_top;
			oor_q <= sel_oor;
		end
	end

	// Commands are held off until the settings are valid again.
	assign busy = recalc_q || div_st.busy || div_st.done;

	// ------------------------------------------------------------------
	// Duty pipeline
	//   s1: capture speed
	//   s2: saturate to full duty (zero speed gives zero duty and no enable)
	//   s3: top * duty
	//   s4: scale by 1/1024, attach settings, drive done
	// ------------------------------------------------------------------
	logic accept;
	assign accept = start && !busy;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [SPEED_W-1:0] speed_s1;
	logic [DUTY_W-1:0]  duty_s2;
	logic               en_s2, en_s3;
	logic [PROD_W-1:0]  prod_s3;
	logic [CS_W-1:0]    cs_s4;
	logic [TOP_W-1:0]   top_s4;
	logic [TOP_W-1:0]   cmp_s4;
	logic               en_s4;
	logic               oor_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		speed_s1 <= speed;

		duty_s2 <= (speed_s1 > SPEED_W'(FULL_DUTY)) ? DUTY_W'(FULL_DUTY)
		                                            : DUTY_W'(speed_s1);
		en_s2   <= (speed_s1 != '0);

		prod_s3 <= PROD_W'(top_q) * PROD_W'(duty_s2);
		en_s3   <= en_s2;

		cs_s4  <= cs_q;
		top_s4 <= top_q;
		cmp_s4 <= prod_s3[DUTY_SHIFT +: TOP_W];
		en_s4  <= en_s3;
		oor_s4 <= oor_q;
	end

	assign done              = v_s4;
	assign clock_select      = cs_s4;
	assign top_value         = top_s4;
	assign compare_value     = cmp_s4;
	assign output_enable     = en_s4;
	assign freq_out_of_range = oor_s4;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted command produced no result after four cycles");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && freq_out_of_range) |-> (clock_select == '0 && top_value == '0 &&
		compare_value == '0))
		else $error("out-of-range result carries nonzero timer settings");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !output_enable) |-> (compare_value == '0))
		else $error("disabled output with nonzero compare");

	a_cmp_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (compare_value <= top_value))
		else $error("compare exceeds top");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the PWM prescaler and duty calculator core.
module tb_top;
	import pwmpd_pkg::*;

	// Run shape
	localparam int WATCHDOG_CYCLES = 2000;  // well above the busy time after a write and the longest sender gap
	localparam int TAIL_CYCLES     = 8;     // done trails a start transfer through the duty pipeline
	localparam int PHASES          = 16;
	localparam int PHASE_ITEMS     = 100;
	localparam int DIR_ROWS        = 23;
	localparam int REPORT_LIMIT    = 10;

	// APB map: frequency at word 0, the other word decodes to nothing
	localparam logic [ADDR_W-1:0] FREQ_ADDR  = {REG_FREQUENCY, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_FREQUENCY, 2'b00};

	typedef struct packed {
		logic [CS_W-1:0]  cs;
		logic [TOP_W-1:0] top;
		logic [TOP_W-1:0] cmp;
		logic             en;
		logic             oor;
	} timer_settings_t;

	// One directed row: frequency to run at, speed command, and an optional
	// hand-typed expectation (typed == 0 means use the predictor).
	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [SPEED_W-1:0] spd;
		logic               typed;
		timer_settings_t    want;
	} dir_row_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic [SPEED_W-1:0] speed   = '0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [ADDR_W-1:0]  paddr   = '0;
	logic [DATA_W-1:0]  pwdata  = '0;

	logic               busy;
	logic               done;
	logic [CS_W-1:0]    clock_select;
	logic [TOP_W-1:0]   top_value;
	logic [TOP_W-1:0]   compare_value;
	logic               output_enable;
	logic               freq_out_of_range;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// Testbench copy of the frequency register, and results still owed by the core
	logic [FREQ_W-1:0]  freq_model = FREQ_W'(RESET_FREQ);
	timer_settings_t    pending_settings[$];
	int                 mismatch_count = 0;
	int                 idle_cycles    = 0;
	dir_row_t           dir_rows[DIR_ROWS];

	pwm_prescaler_and_duty_calc_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.speed             (speed),
		.done              (done),
		.clock_select      (clock_select),
		.top_value         (top_value),
		.compare_value     (compare_value),
		.output_enable     (output_enable),
		.freq_out_of_range (freq_out_of_range),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Timer settings for one speed command at a given frequency. Period is
	// clock/freq; the first prescale 2^k whose scaled top limit exceeds the
	// period wins. Zero frequency or a period too long for 2^14 flags out of
	// range with a stopped timer.
	function automatic timer_settings_t compute_timer_settings(
		input logic [FREQ_W-1:0] freq, input logic [SPEED_W-1:0] spd);
		timer_settings_t  r;
		longint unsigned  cycles;
		longint unsigned  top;
		longint unsigned  duty;
		bit               found;
		r     = '0;
		r.oor = 1'b1;
		top   = 0;
		found = 0;
		if (freq != 0) begin
			cycles = longint'(CLOCK_HZ) / longint'(freq);
			for (int k = 0; k <= int'(MAX_PRESCALE_EXP); k++) begin
				if (!found && cycles < (longint'(TIMER_TOP_LIMIT) << k)) begin
					found = 1;
					top   = cycles >> k;
					r.cs  = CS_W'(k + 1);
					r.oor = 1'b0;
				end
			end
		end
		r.top = TOP_W'(top);
		if (spd == 0) begin
			r.en  = 1'b0;
			r.cmp = '0;
		end else begin
			// anything past full duty saturates
			duty  = (spd > FULL_DUTY) ? longint'(FULL_DUTY) : longint'(spd);
			r.en  = 1'b1;
			r.cmp = TOP_W'((top * duty) >> DUTY_SHIFT);
		end
		return r;
	endfunction

	function automatic dir_row_t typed_row(input logic [FREQ_W-1:0] f,
		input logic [SPEED_W-1:0] s, input int cs, input int top, input int cmp,
		input logic en, input logic oor);
		dir_row_t row;
		row.freq     = f;
		row.spd      = s;
		row.typed    = 1'b1;
		row.want.cs  = CS_W'(cs);
		row.want.top = TOP_W'(top);
		row.want.cmp = TOP_W'(cmp);
		row.want.en  = en;
		row.want.oor = oor;
		return row;
	endfunction

	function automatic dir_row_t predicted_row(input logic [FREQ_W-1:0] f,
		input logic [SPEED_W-1:0] s);
		dir_row_t row;
		row      = '0;
		row.freq = f;
		row.spd  = s;
		return row;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SPEED_W'(FULL_DUTY);
			2, 3, 4: return SPEED_W'($urandom_range(1, FULL_DUTY));
			5, 6: return SPEED_W'($urandom_range(FULL_DUTY + 1, 16'hFFFF));
			default: return SPEED_W'($urandom);
		endcase
	endfunction

	// Edge frequencies, raw 26-bit noise, log-spread values, and the usual motor range
	function automatic logic [FREQ_W-1:0] pick_frequency();
		int unsigned e;
		int unsigned lo;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 6))
					0: return '0;
					1: return FREQ_W'(1);
					2: return FREQ_W'(2);
					3: return FREQ_W'(3);
					4: return FREQ_W'(46921);
					5: return FREQ_W'(CLOCK_HZ);
					default: return '1;
				endcase
			end
			1, 2: return FREQ_W'($urandom);
			3, 4, 5, 6: begin
				e  = $urandom_range(0, FREQ_W - 1);
				lo = 1 << e;
				return FREQ_W'($urandom_range((lo << 1) - 1, lo));
			end
			default: return FREQ_W'($urandom_range(100, 100000));
		endcase
	endfunction

	// Present one speed command and hold it until the core takes it.
	// start is only dropped when a gap is wanted, so back-to-back items
	// keep it high.
	task automatic send_speed(input logic [SPEED_W-1:0] spd, input int gap,
		input logic typed, input timer_settings_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		speed <= spd;
		do
			@(posedge clk);
		while (!(start && !busy));
		pending_settings.push_back(typed ? want : compute_timer_settings(freq_model, spd));
	endtask

	// Stop sending and let every owed result come back
	task automatic drain_results();
		start <= 1'b0;
		while (pending_settings.size() != 0)
			@(posedge clk);
	endtask

	// Two-phase APB write; junk in the upper data bits must not reach the register
	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [FREQ_W-1:0] value);
		logic [DATA_W-1:0] noise;
		noise   = $urandom;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {noise[DATA_W-1:FREQ_W], value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == FREQ_ADDR)
			freq_model = value;
	endtask

	// Result check and watchdog. Outputs are sampled at the edge, before the
	// core's own updates land, so the values seen belong to the cycle ending here.
	always @(posedge clk) begin
		timer_settings_t want;
		timer_settings_t got;
		if (arst_n) begin
			if (done) begin
				got = '{clock_select, top_value, compare_value, output_enable, freq_out_of_range};
				if (pending_settings.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result with nothing pending: cs=%0d top=%0d cmp=%0d en=%0d oor=%0d",
							$realtime, got.cs, got.top, got.cmp, got.en, got.oor);
				end else begin
					want = pending_settings.pop_front();
					if (got.cs !== want.cs || got.top !== want.top || got.cmp !== want.cmp ||
						got.en !== want.en || got.oor !== want.oor) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: mismatch exp cs=%0d top=%0d cmp=%0d en=%0d oor=%0d, got cs=%0d top=%0d cmp=%0d en=%0d oor=%0d",
								$realtime, want.cs, want.top, want.cmp, want.en, want.oor,
								got.cs, got.top, got.cmp, got.en, got.oor);
					end
				end
			end
			// any transfer on either port counts as progress
			if (done || (start && !busy) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("pwm_prescaler_and_duty_calc_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t row;
		// Reset-value frequency (10 kHz: prescale 8, top 600), duty corners
		dir_rows[0]  = typed_row(10000, 0, 4, 600, 0, 1'b0, 1'b0);
		dir_rows[1]  = typed_row(10000, 1024, 4, 600, 600, 1'b1, 1'b0);
		dir_rows[2]  = typed_row(10000, 512, 4, 600, 300, 1'b1, 1'b0);
		dir_rows[3]  = typed_row(10000, 16'hFFFF, 4, 600, 600, 1'b1, 1'b0);
		dir_rows[4]  = typed_row(10000, 1, 4, 600, 0, 1'b1, 1'b0);
		dir_rows[5]  = predicted_row(10000, 1025);
		// Frequency equal to the clock: the shortest nonzero period
		dir_rows[6]  = typed_row(FREQ_W'(CLOCK_HZ), 1024, 1, 1, 1, 1'b1, 1'b0);
		dir_rows[7]  = typed_row(FREQ_W'(CLOCK_HZ), 1023, 1, 1, 0, 1'b1, 1'b0);
		// Frequency above the clock: zero period, fastest prescale
		dir_rows[8]  = typed_row(26'h3FFFFFF, 1024, 1, 0, 0, 1'b1, 1'b0);
		// Zero frequency treated as unreachable
		dir_rows[9]  = typed_row(0, 0, 0, 0, 0, 1'b0, 1'b1);
		dir_rows[10] = typed_row(0, 1024, 0, 0, 0, 1'b1, 1'b1);
		// Too slow for the largest prescale
		dir_rows[11] = typed_row(1, 16'hFFFF, 0, 0, 0, 1'b1, 1'b1);
		dir_rows[12] = typed_row(2, 700, 0, 0, 0, 1'b1, 1'b1);
		// Slowest reachable: prescale 2^14
		dir_rows[13] = typed_row(3, 1024, 15, 976, 976, 1'b1, 1'b0);
		dir_rows[14] = typed_row(3, 16'hFFFF, 15, 976, 976, 1'b1, 1'b0);
		dir_rows[15] = typed_row(3, 0, 15, 976, 0, 1'b0, 1'b0);
		// Largest top without prescaling, and the step into prescale 2
		dir_rows[16] = typed_row(46921, 1024, 1, 1022, 1022, 1'b1, 1'b0);
		dir_rows[17] = predicted_row(46921, 1023);
		dir_rows[18] = predicted_row(46920, 1024);
		dir_rows[19] = predicted_row(10000, 16'hAAAA);
		dir_rows[20] = predicted_row(10000, 16'h5555);
		dir_rows[21] = predicted_row(FREQ_W'(CLOCK_HZ + 1), 512);
		dir_rows[22] = predicted_row(26'h2AAAAAA, 16'h0155);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A write to the unmapped word must leave the reset frequency alone
		write_register(SPARE_ADDR, FREQ_W'($urandom));

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			if (row.freq != freq_model) begin
				drain_results();
				write_register(FREQ_ADDR, row.freq);
			end
			send_speed(row.spd, pick_gap(), row.typed, row.want);
		end

		// Random phases: each starts idle with a new frequency; every fourth
		// runs back to back with no sender gaps.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			if (p % 5 == 2)
				write_register(SPARE_ADDR, FREQ_W'($urandom));
			write_register(FREQ_ADDR, pick_frequency());
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_speed(pick_speed(), (p % 4 == 3) ? 0 : pick_gap(), 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_settings.size() == 0)
			$display("pwm_prescaler_and_duty_calc_core regression: pass");
		else
			$display("pwm_prescaler_and_duty_calc_core regression: fail");
		$finish;
	end

endmodule
